[src/pvs_pkg.sv]
// ============================================================================
// pvs_pkg
// Shared types and constants of the polyphonic voice synthesizer.
// ============================================================================
package pvs_pkg;

    // Commands carried on the input port.
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_NOTE_ON = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_GAIN    = 2'd0;
    localparam logic [1:0] REG_ATTACK  = 2'd1;
    localparam logic [1:0] REG_DECAY   = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    localparam logic [15:0] GAIN_RST    = 16'd11796;
    localparam logic [15:0] ATTACK_RST  = 16'd576;
    localparam logic [31:0] DECAY_RST   = 32'd4294815186;
    localparam logic [31:0] RELEASE_RST = 32'd4294340992;

    // Envelope constants, Q0.32.
    localparam logic [31:0] ENV_FLOOR   = 32'd644245094;
    localparam logic [31:0] DECAY_START = 32'd3650722202;
    localparam logic [31:0] ENV_SILENT  = 32'd4294967;
    localparam logic [31:0] UNITY_Q32   = 32'hFFFF_FFFF;
    localparam logic [23:0] AGE_MAX     = 24'hFF_FFFF;

    // Sine polynomial constants, Q1.30.
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [31:0] phase;
        logic [30:0] step;
        logic [23:0] age;
        logic [23:0] hold;
        logic [15:0] velocity;
        logic [31:0] decay_term;
        logic [31:0] release_term;
    } voice_t;

    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;

endpackage

[src/pvs_div.sv]
// ============================================================================
// pvs_div
// Radix-2 restoring divider for the attack ramp: floor(num * 2^32 / den),
// valid for num < den. One quotient bit per cycle.
// ============================================================================
module pvs_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  pvs_pkg::div_req_t req,
    output pvs_pkg::div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [31:0] quot_reg, quot_next;
    logic [16:0] rem_shift;
    logic        take;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        rem_shift = {rem_reg, 1'b0};
        take      = rem_shift >= {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = req.num;
            den_next  = req.den;
            quot_next = 32'd0;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits in 16 bits.
            rem_next  = take ? 16'(rem_shift - {1'b0, den_reg}) : rem_shift[15:0];
            quot_next = {quot_reg[30:0], take};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[src/polyphonic_voice_synth.sv]
// ============================================================================
// polyphonic_voice_synth
// Polyphonic synthesizer with voice allocation, per-voice envelope and mix.
// ============================================================================
// Tick: voices in turn; an idle one is only read, an active one steps through read,
//   load, term, envelope, divide (in the attack ramp), release, check, wave,
//   envelope multiply and write-back (a silent voice skips wave and envelope
//   multiply); then mix and output. Note on: an idle voice if any, else the
//   oldest, found by scanning the ages through the voice memory's single read port.
// One item at a time; busy is high until the item is done. The sample strobe lasts
//   one cycle. Reset sets control and config registers and frees all voices at once.
module polyphonic_voice_synth
#(
    parameter int VOICE_COUNT      = 16,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [30:0] phase_step,
    input  logic [15:0] velocity,
    input  logic [23:0] hold_samples,
    output logic        sample_valid,
    output logic [15:0] sample,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int PW     = 33 + IDX_W;
    localparam int SUM_W  = 33 + VIDX_W;
    localparam int MIX_W  = SUM_W + 16 - 31;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_LOAD = 4'd2;
    localparam logic [3:0] S_TERM = 4'd3;
    localparam logic [3:0] S_ENV  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_REL  = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_WAVE = 4'd8;
    localparam logic [3:0] S_ENVM = 4'd9;
    localparam logic [3:0] S_WB   = 4'd10;
    localparam logic [3:0] S_MIX  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;
    localparam logic [3:0] S_SRD  = 4'd13;
    localparam logic [3:0] S_SCMP = 4'd14;
    localparam logic [3:0] S_NOTE = 4'd15;

    typedef logic signed [31:0] rom_t [SINE_TABLE_DEPTH];

    // Sine entry k in Q1.30 from an odd polynomial of degree 11 per quadrant.
    function automatic logic signed [31:0] sine_entry(input longint unsigned k);
        longint unsigned t, quad, r, x, x2, f, s;
        t    = ((k << 32) / 64'(SINE_TABLE_DEPTH)) & 64'hFFFF_FFFF;
        quad = t >> 30;
        r    = t & 64'h3FFF_FFFF;
        if ((quad & 64'd1) != 64'd0)
            r = pvs_pkg::Q30_ONE - r;
        x  = (r * pvs_pkg::HALF_PI_Q30 + (pvs_pkg::Q30_ONE >> 1)) >> 30;
        x2 = (x * x + (pvs_pkg::Q30_ONE >> 1)) >> 30;
        f  = pvs_pkg::Q30_ONE - x2 / 64'd110;
        f  = pvs_pkg::Q30_ONE - ((x2 * f) >> 30) / 64'd72;
        f  = pvs_pkg::Q30_ONE - ((x2 * f) >> 30) / 64'd42;
        f  = pvs_pkg::Q30_ONE - ((x2 * f) >> 30) / 64'd20;
        f  = pvs_pkg::Q30_ONE - ((x2 * f) >> 30) / 64'd6;
        s  = (x * f + (pvs_pkg::Q30_ONE >> 1)) >> 30;
        if (s > pvs_pkg::Q30_ONE)
            s = pvs_pkg::Q30_ONE;
        return (quad >= 64'd2) ? -32'(s) : 32'(s);
    endfunction

    function automatic rom_t build_rom();
        rom_t tbl;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            tbl[k] = sine_entry(64'(k));
        return tbl;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Configuration registers.
    logic [15:0] gain_reg, attack_reg;
    logic [31:0] decay_reg, release_reg;
    logic        cfg_write;

    // Control.
    logic [3:0]             state_reg, state_next;
    logic [VIDX_W-1:0]      vidx_reg, vidx_next;
    logic [VOICE_COUNT-1:0] active_reg, active_next;
    logic                   valid_reg, valid_next;

    // Datapath.
    logic [VIDX_W-1:0] best_reg, best_next;
    logic [23:0]       best_age_reg, best_age_next;
    logic [30:0]       step_in_reg, step_in_next;
    logic [15:0]       vel_in_reg, vel_in_next;
    logic [23:0]       hold_in_reg, hold_in_next;
    pvs_pkg::voice_t   vc_reg, vc_next;
    logic              adv_reg, adv_next;
    logic [31:0]       env_reg, env_next;
    logic [IDX_W-1:0]  idx1_reg, idx1_next, idx2_reg, idx2_next;
    logic              wneg_reg, wneg_next;
    logic [30:0]       m1_reg, m1_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [MIX_W-1:0]  mix_mag_reg, mix_mag_next;
    logic              mix_neg_reg, mix_neg_next;
    logic [15:0]       sample_reg, sample_next;

    // Voice memory.
    pvs_pkg::voice_t mem [VOICE_COUNT];
    pvs_pkg::voice_t rd_reg;
    pvs_pkg::voice_t wdata;
    logic            mem_we;

    logic signed [31:0] s1_reg, s2_reg;

    pvs_pkg::div_req_t div_req;
    pvs_pkg::div_rsp_t div_rsp;

    // Combinational helpers.
    logic              accept, last_voice, found, upd;
    logic [VIDX_W-1:0] slot;
    logic [23:0]       a_val;
    logic              in_attack, at_hold, dec_upd, rel_upd;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_full;
    logic [32:0]       env_sum;
    logic [PW-1:0]     p1, p2;
    logic signed [34:0] wave;
    logic [34:0]       wave_abs;
    logic [49:0]       m1_full;
    logic [63:0]       m2_full;
    logic [SUM_W-1:0]  acc_abs;
    logic [SUM_W+15:0] mix_full;

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign last_voice = (vidx_reg == VIDX_W'(VOICE_COUNT - 1));
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            pvs_pkg::REG_GAIN:    prdata = {16'd0, gain_reg};
            pvs_pkg::REG_ATTACK:  prdata = {16'd0, attack_reg};
            pvs_pkg::REG_DECAY:   prdata = decay_reg;
            pvs_pkg::REG_RELEASE: prdata = release_reg;
            default:              prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        found = 1'b0;
        slot  = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                found = 1'b1;
                slot  = VIDX_W'(i);
            end
        end
    end

    assign a_val     = (vc_reg.age < vc_reg.hold) ? vc_reg.age : vc_reg.hold;
    assign in_attack = a_val < {8'd0, attack_reg};
    assign at_hold   = vc_reg.age >= vc_reg.hold;
    assign dec_upd   = adv_reg && (vc_reg.age > {8'd0, attack_reg})
                       && (vc_reg.age <= vc_reg.hold);
    assign rel_upd   = adv_reg && (vc_reg.age > vc_reg.hold);

    // One shared Q0.32 multiplier for the term updates and the release scale.
    always_comb
    begin
        if (state_reg == S_REL)
        begin
            mul_a = env_reg;
            mul_b = vc_reg.release_term;
        end
        else if (vc_reg.age <= vc_reg.hold)
        begin
            mul_a = vc_reg.decay_term;
            mul_b = decay_reg;
        end
        else
        begin
            mul_a = vc_reg.release_term;
            mul_b = release_reg;
        end
    end

    assign mul_full = {32'd0, mul_a} * {32'd0, mul_b} + 64'h8000_0000;
    assign env_sum  = {1'b0, vc_reg.decay_term} + {1'b0, pvs_pkg::ENV_FLOOR};
    assign p1       = PW'(vc_reg.phase[30:0]) * PW'(SINE_TABLE_DEPTH);
    assign p2       = PW'(vc_reg.phase) * PW'(SINE_TABLE_DEPTH);
    assign wave     = (35'(s1_reg) <<< 2) + 35'(s2_reg);
    assign wave_abs = wave[34] ? 35'(-wave) : 35'(wave);
    assign m1_full  = 50'(wave_abs[32:0]) * 50'(vc_reg.velocity) + 50'(1 << 17);
    assign m2_full  = 64'(m1_reg) * 64'(env_reg) + 64'h8000_0000;
    assign acc_abs  = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign mix_full = (SUM_W + 16)'(acc_abs) * (SUM_W + 16)'(gain_reg)
                      + (SUM_W + 16)'(1 << 30);

    assign upd = (vidx_reg == '0) || (rd_reg.age > best_age_reg);

    assign div_req.start = (state_reg == S_ENV) && in_attack;
    assign div_req.num   = a_val[15:0];
    assign div_req.den   = attack_reg;

    always_comb
    begin
        state_next    = state_reg;
        vidx_next     = vidx_reg;
        active_next   = active_reg;
        valid_next    = 1'b0;
        best_next     = best_reg;
        best_age_next = best_age_reg;
        step_in_next  = step_in_reg;
        vel_in_next   = vel_in_reg;
        hold_in_next  = hold_in_reg;
        vc_next       = vc_reg;
        adv_next      = adv_reg;
        env_next      = env_reg;
        idx1_next     = idx1_reg;
        idx2_next     = idx2_reg;
        wneg_next     = wneg_reg;
        m1_next       = m1_reg;
        acc_next      = acc_reg;
        mix_mag_next  = mix_mag_reg;
        mix_neg_next  = mix_neg_reg;
        sample_next   = sample_reg;
        mem_we        = 1'b0;
        wdata         = vc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == pvs_pkg::CMD_NOTE_ON)
                    begin
                        step_in_next = phase_step;
                        vel_in_next  = velocity;
                        hold_in_next = hold_samples;
                        if (found)
                        begin
                            vidx_next  = slot;
                            state_next = S_NOTE;
                        end
                        else
                        begin
                            vidx_next  = '0;
                            state_next = S_SRD;
                        end
                    end
                    else
                    begin
                        vidx_next  = '0;
                        acc_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_SRD:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                // Oldest voice wins; a strict compare keeps the lowest index on ties.
                if (upd)
                begin
                    best_next     = vidx_reg;
                    best_age_next = rd_reg.age;
                end
                if (last_voice)
                begin
                    vidx_next  = upd ? vidx_reg : best_reg;
                    state_next = S_NOTE;
                end
                else
                begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_NOTE:
            begin
                mem_we             = 1'b1;
                wdata.phase        = 32'd0;
                wdata.step         = step_in_reg;
                wdata.age          = 24'd0;
                wdata.hold         = hold_in_reg;
                wdata.velocity     = vel_in_reg;
                wdata.decay_term   = pvs_pkg::DECAY_START;
                wdata.release_term = pvs_pkg::UNITY_Q32;
                active_next[vidx_reg] = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                if (active_reg[vidx_reg])
                    state_next = S_LOAD;
                else if (last_voice)
                    state_next = S_MIX;
                else
                    vidx_next = vidx_reg + 1'b1;
            end
            S_LOAD:
            begin
                vc_next       = rd_reg;
                vc_next.phase = rd_reg.phase + {1'b0, rd_reg.step};
                adv_next      = (rd_reg.age != pvs_pkg::AGE_MAX);
                if (rd_reg.age != pvs_pkg::AGE_MAX)
                    vc_next.age = rd_reg.age + 24'd1;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                if (dec_upd)
                    vc_next.decay_term = mul_full[63:32];
                if (rel_upd)
                    vc_next.release_term = mul_full[63:32];
                idx1_next  = p1[31 +: IDX_W];
                idx2_next  = p2[32 +: IDX_W];
                state_next = S_ENV;
            end
            S_ENV:
            begin
                if (in_attack)
                    state_next = S_DIV;
                else
                begin
                    env_next   = env_sum[32] ? pvs_pkg::UNITY_Q32 : env_sum[31:0];
                    state_next = S_REL;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    env_next   = div_rsp.quot;
                    state_next = S_REL;
                end
            end
            S_REL:
            begin
                if (at_hold)
                    env_next = mul_full[63:32];
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (at_hold && (env_reg < pvs_pkg::ENV_SILENT))
                begin
                    active_next[vidx_reg] = 1'b0;
                    state_next = S_WB;
                end
                else
                    state_next = S_WAVE;
            end
            S_WAVE:
            begin
                wneg_next  = wave[34];
                m1_next    = m1_full[48:18];
                state_next = S_ENVM;
            end
            S_ENVM:
            begin
                if (wneg_reg)
                    acc_next = acc_reg - SUM_W'(m2_full[62:32]);
                else
                    acc_next = acc_reg + SUM_W'(m2_full[62:32]);
                state_next = S_WB;
            end
            S_WB:
            begin
                mem_we = 1'b1;
                if (last_voice)
                    state_next = S_MIX;
                else
                begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_MIX:
            begin
                mix_neg_next = acc_reg[SUM_W-1];
                mix_mag_next = mix_full[SUM_W+15:31];
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                valid_next = 1'b1;
                if (mix_neg_reg)
                    sample_next = (mix_mag_reg > MIX_W'(32768)) ? 16'h8000
                                  : 16'(~mix_mag_reg + 1'b1);
                else
                    sample_next = (mix_mag_reg > MIX_W'(32767)) ? 16'h7FFF
                                  : mix_mag_reg[15:0];
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vidx_reg    <= '0;
            active_reg  <= '0;
            valid_reg   <= 1'b0;
            gain_reg    <= pvs_pkg::GAIN_RST;
            attack_reg  <= pvs_pkg::ATTACK_RST;
            decay_reg   <= pvs_pkg::DECAY_RST;
            release_reg <= pvs_pkg::RELEASE_RST;
        end
        else
        begin
            state_reg  <= state_next;
            vidx_reg   <= vidx_next;
            active_reg <= active_next;
            valid_reg  <= valid_next;
            if (cfg_write)
            begin
                case (paddr[3:2])
                    pvs_pkg::REG_GAIN:    gain_reg    <= pwdata[15:0];
                    pvs_pkg::REG_ATTACK:  attack_reg  <= pwdata[15:0];
                    pvs_pkg::REG_DECAY:   decay_reg   <= pwdata;
                    pvs_pkg::REG_RELEASE: release_reg <= pwdata;
                    default:              gain_reg    <= gain_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        step_in_reg  <= step_in_next;
        vel_in_reg   <= vel_in_next;
        hold_in_reg  <= hold_in_next;
        vc_reg       <= vc_next;
        adv_reg      <= adv_next;
        env_reg      <= env_next;
        idx1_reg     <= idx1_next;
        idx2_reg     <= idx2_next;
        wneg_reg     <= wneg_next;
        m1_reg       <= m1_next;
        acc_reg      <= acc_next;
        mix_mag_reg  <= mix_mag_next;
        mix_neg_reg  <= mix_neg_next;
        sample_reg   <= sample_next;
    end

    // Voice memory: one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[vidx_reg] <= wdata;
        rd_reg <= mem[vidx_reg];
    end

    // Sine ROM with two registered read ports.
    always_ff @(posedge clk)
    begin
        s1_reg <= SINE_ROM[idx1_reg];
        s2_reg <= SINE_ROM[idx2_reg];
    end

    pvs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sample_valid = valid_reg;
    assign sample       = sample_reg;

`ifndef ASSERT_OFF
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid |=> !sample_valid)
        else $error("sample strobe held for more than one cycle");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_note_claims_voice: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NOTE) |=> active_reg[$past(vidx_reg)])
        else $error("note on did not claim its voice");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");
`endif

endmodule

[tb/tb_polyphonic_voice_synth.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_polyphonic_voice_synth
// Self-checking testbench: directed rows, then random note-on and tick items,
// each sample compared with an in-bench voice and envelope predictor.
// ============================================================================
module tb_polyphonic_voice_synth;

    localparam int NV = 16;
    localparam int DEPTH = 1024;
    localparam longint CYCLE_LIMIT = 6000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        command = pvs_pkg::CMD_TICK;
    logic [30:0] phase_step = '0;
    logic [15:0] velocity = '0;
    logic [23:0] hold_samples = '0;
    logic        sample_valid;
    logic [15:0] sample;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    polyphonic_voice_synth dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state.
    bit [15:0] p_gain;
    bit [15:0] p_attack;
    bit [31:0] p_decay;
    bit [31:0] p_release;
    bit        v_active[NV];
    bit [31:0] v_phase[NV];
    bit [30:0] v_step[NV];
    bit [23:0] v_age[NV];
    bit [23:0] v_hold[NV];
    bit [15:0] v_vel[NV];
    bit [31:0] v_decay[NV];
    bit [31:0] v_release[NV];
    longint    sine_tab[DEPTH];

    logic [15:0] samples_due[$];
    int  err_count = 0;
    bit  all_sent = 1'b0;
    longint cycles = 0;

    function automatic bit [31:0] mul_q32(bit [31:0] a, bit [31:0] b);
        longint unsigned prod;
        prod = longint'(a) * longint'(b) + 64'h8000_0000;
        return prod[63:32];
    endfunction

    function automatic longint sine_entry(int k);
        bit [31:0] t;
        bit [1:0]  quad;
        longint unsigned r, x, x2, f, s;
        t = 32'(k) << 22;
        quad = t[31:30];
        r = t & 32'h3FFF_FFFF;
        if (quad[0])
            r = pvs_pkg::Q30_ONE - r;
        x = (r * pvs_pkg::HALF_PI_Q30 + (pvs_pkg::Q30_ONE >> 1)) >> 30;
        x2 = (x * x + (pvs_pkg::Q30_ONE >> 1)) >> 30;
        f = pvs_pkg::Q30_ONE - x2 / 110;
        f = pvs_pkg::Q30_ONE - ((x2 * f) >> 30) / 72;
        f = pvs_pkg::Q30_ONE - ((x2 * f) >> 30) / 42;
        f = pvs_pkg::Q30_ONE - ((x2 * f) >> 30) / 20;
        f = pvs_pkg::Q30_ONE - ((x2 * f) >> 30) / 6;
        s = (x * f + (pvs_pkg::Q30_ONE >> 1)) >> 30;
        if (s > pvs_pkg::Q30_ONE)
            s = pvs_pkg::Q30_ONE;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint advance_voice(int v);
        bit [23:0] age;
        bit [23:0] a;
        bit [31:0] ph;
        bit        moved;
        bit        neg;
        longint unsigned env, mag;
        longint wave;
        age = v_age[v];
        moved = 1'b0;
        if (age < pvs_pkg::AGE_MAX)
        begin
            age++;
            moved = 1'b1;
        end
        v_age[v] = age;
        ph = v_phase[v] + {1'b0, v_step[v]};
        v_phase[v] = ph;
        a = (age < v_hold[v]) ? age : v_hold[v];
        if (moved && age > p_attack && age <= v_hold[v])
            v_decay[v] = mul_q32(v_decay[v], p_decay);
        if (moved && age > v_hold[v])
            v_release[v] = mul_q32(v_release[v], p_release);
        if (a < p_attack)
            env = (longint'(a) << 32) / p_attack;
        else
        begin
            env = longint'(v_decay[v]) + pvs_pkg::ENV_FLOOR;
            if (env > 64'hFFFF_FFFF)
                env = 64'hFFFF_FFFF;
        end
        if (age >= v_hold[v])
        begin
            env = mul_q32(env[31:0], v_release[v]);
            if (env < pvs_pkg::ENV_SILENT)
            begin
                v_active[v] = 1'b0;
                return 0;
            end
        end
        wave = 4 * sine_tab[ph[30:21]] + sine_tab[ph[31:22]];
        neg = wave < 0;
        mag = neg ? -wave : wave;
        mag = (mag * v_vel[v] + (64'd1 << 17)) >> 18;
        mag = (mag * env + 64'h8000_0000) >> 32;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // Applies one accepted transaction to the predictor state; returns 1 with
    // the expected sample for a tick.
    function automatic bit predict_item(bit cmd, bit [30:0] stp, bit [15:0] vel,
                                        bit [23:0] hld, output logic [15:0] smp);
        int slot;
        longint sum;
        longint unsigned mag;
        smp = '0;
        if (cmd == pvs_pkg::CMD_NOTE_ON)
        begin
            slot = 0;
            for (int v = 0; v < NV; v++)
            begin
                if (!v_active[v])
                begin
                    slot = v;
                    break;
                end
                if (v_age[v] > v_age[slot])
                    slot = v;
            end
            v_active[slot] = 1'b1;
            v_phase[slot] = '0;
            v_age[slot] = '0;
            v_step[slot] = stp;
            v_vel[slot] = vel;
            v_hold[slot] = hld;
            v_decay[slot] = pvs_pkg::DECAY_START;
            v_release[slot] = pvs_pkg::UNITY_Q32;
            return 1'b0;
        end
        sum = 0;
        for (int v = 0; v < NV; v++)
            if (v_active[v])
                sum += advance_voice(v);
        mag = (sum < 0) ? -sum : sum;
        mag = (mag * p_gain + (64'd1 << 30)) >> 31;
        if (sum < 0)
            smp = (mag > 32768) ? 16'h8000 : 16'(-longint'(mag));
        else
            smp = (mag > 32767) ? 16'h7FFF : 16'(mag);
        return 1'b1;
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pvs_pkg::REG_GAIN:    p_gain = value[15:0];
            pvs_pkg::REG_ATTACK:  p_attack = value[15:0];
            pvs_pkg::REG_DECAY:   p_decay = value;
            default:              p_release = value;
        endcase
    endtask

    // Drives one transaction and holds start until busy is seen low at an edge.
    // The caller lowers start when a gap follows.
    task automatic send_item(bit cmd, bit [30:0] stp, bit [15:0] vel, bit [23:0] hld,
                             bit typed, logic [15:0] typed_smp);
        logic [15:0] smp;
        start <= 1'b1;
        command <= cmd;
        phase_step <= stp;
        velocity <= vel;
        hold_samples <= hld;
        do
            @(posedge clk);
        while (busy);
        if (predict_item(cmd, stp, vel, hld, smp))
            samples_due.push_back(typed ? typed_smp : smp);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (samples_due.size() != 0 || busy)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    typedef struct {
        bit          cmd;
        bit [30:0]   stp;
        bit [15:0]   vel;
        bit [23:0]   hld;
        int          reps;
        bit          typed;
        logic [15:0] smp;
    } row_t;

    row_t directed[] = '{
        '{pvs_pkg::CMD_TICK,    31'h7FFF_FFFF, 16'hFFFF, 24'hFF_FFFF, 2, 1'b1, 16'h0000},
        '{pvs_pkg::CMD_NOTE_ON, 31'h4000_0000, 16'hFFFF, 24'h00_0000, 1, 1'b0, 16'h0},
        '{pvs_pkg::CMD_TICK,    31'h0,         16'h0,    24'h0,       3, 1'b0, 16'h0},
        '{pvs_pkg::CMD_NOTE_ON, 31'h0,         16'h0,    24'hFF_FFFF, 1, 1'b0, 16'h0},
        '{pvs_pkg::CMD_NOTE_ON, 31'h7FFF_FFFF, 16'h8000, 24'h00_0005, 1, 1'b0, 16'h0},
        '{pvs_pkg::CMD_NOTE_ON, 31'h0123_4567, 16'hFFFF, 24'h00_0300, 1, 1'b0, 16'h0},
        '{pvs_pkg::CMD_TICK,    31'h0,         16'h0,    24'h0,       8, 1'b0, 16'h0},
        '{pvs_pkg::CMD_NOTE_ON, 31'h2AAA_AAAA, 16'h5555, 24'h00_0040, 14, 1'b0, 16'h0},
        '{pvs_pkg::CMD_TICK,    31'h0,         16'h0,    24'h0,       2, 1'b0, 16'h0},
        '{pvs_pkg::CMD_NOTE_ON, 31'h1555_5555, 16'hAAAA, 24'h00_0010, 3, 1'b0, 16'h0},
        '{pvs_pkg::CMD_TICK,    31'h0,         16'h0,    24'h0,       4, 1'b0, 16'h0}
    };

    always @(posedge clk)
    begin
        if (rst_n && sample_valid)
        begin
            if (samples_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected sample %0d", $signed(sample));
            end
            else
            begin
                if (sample !== samples_due[0])
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("sample mismatch: expected %0d actual %0d",
                                 $signed(samples_due[0]), $signed(sample));
                end
                void'(samples_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int idle_pct;
        int gap;
        bit cmd;
        bit [30:0] stp;
        bit [23:0] hld;
        for (int k = 0; k < DEPTH; k++)
            sine_tab[k] = sine_entry(k);
        p_gain = pvs_pkg::GAIN_RST;
        p_attack = pvs_pkg::ATTACK_RST;
        p_decay = pvs_pkg::DECAY_RST;
        p_release = pvs_pkg::RELEASE_RST;
        for (int v = 0; v < NV; v++)
            v_active[v] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            for (int n = 0; n < directed[i].reps; n++)
                send_item(directed[i].cmd, directed[i].stp, directed[i].vel,
                          directed[i].hld, directed[i].typed, directed[i].smp);

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    idle_pct = 0;
                    reg_write(pvs_pkg::REG_GAIN, 32'd65535);
                    reg_write(pvs_pkg::REG_ATTACK, 32'd1);
                    reg_write(pvs_pkg::REG_DECAY, 32'd0);
                    reg_write(pvs_pkg::REG_RELEASE, 32'hFFFF_FFFF);
                end
                1:
                begin
                    idle_pct = 84;
                    reg_write(pvs_pkg::REG_GAIN, 32'd0);
                    reg_write(pvs_pkg::REG_ATTACK, 32'd65535);
                    reg_write(pvs_pkg::REG_DECAY, 32'hFFFF_FFFF);
                    reg_write(pvs_pkg::REG_RELEASE, 32'd0);
                end
                2:
                begin
                    idle_pct = 0;
                    // No attack ramp: the decay runs from the first tick.
                    reg_write(pvs_pkg::REG_GAIN, $urandom_range(65535));
                    reg_write(pvs_pkg::REG_ATTACK, 32'd0);
                    reg_write(pvs_pkg::REG_DECAY, $urandom | 32'hF000_0000);
                    reg_write(pvs_pkg::REG_RELEASE, $urandom | 32'hE000_0000);
                end
                default:
                begin
                    idle_pct = 35;
                    reg_write(pvs_pkg::REG_GAIN, pvs_pkg::GAIN_RST);
                    reg_write(pvs_pkg::REG_ATTACK, $urandom_range(200, 1));
                    reg_write(pvs_pkg::REG_DECAY, pvs_pkg::DECAY_RST);
                    reg_write(pvs_pkg::REG_RELEASE, $urandom | 32'hF800_0000);
                end
            endcase
            for (int n = 0; n < 285; n++)
            begin
                // Idle in bursts so that some stretches run back to back.
                if (idle_pct != 0 && (n % 40) < 30 && $urandom_range(99) < idle_pct)
                begin
                    gap = $urandom_range(8, 1);
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                cmd = ($urandom_range(99) < 30) ? pvs_pkg::CMD_NOTE_ON : pvs_pkg::CMD_TICK;
                stp = ($urandom_range(99) < 70) ? 31'($urandom_range(32'h4000_0000))
                                                : 31'($urandom);
                case ($urandom_range(9))
                    0:       hld = 24'($urandom);
                    1, 2, 3: hld = 24'($urandom_range(3000));
                    default: hld = 24'($urandom_range(300));
                endcase
                send_item(cmd, stp, 16'($urandom), hld, 1'b0, 16'h0);
            end
        end
        settle();
        all_sent = 1'b1;
    end

    initial
    begin
        wait (all_sent);
        if (err_count == 0 && samples_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
src/pvs_pkg.sv
src/pvs_div.sv
src/polyphonic_voice_synth.sv
tb/tb_polyphonic_voice_synth.sv
